### rtl/dpw_pkg.sv
// shared types, widths and constants for the depth pixel to world point datapath
package dpw_pkg;

    // field and datapath widths
    localparam int DEPTH_W    = 16;
    localparam int UV_W       = 16;
    localparam int SUMSQ_W    = 32;
    localparam int SQ_FRAC    = 26;
    localparam int RAD_W      = SUMSQ_W + SQ_FRAC;
    localparam int ROOT_W     = 29;
    localparam int SQ_STAGES  = ROOT_W;
    localparam int REM_W      = 32;
    localparam int DEN_W      = 39;
    localparam int NUM_SHIFT  = 46;
    localparam int NUM_W      = DEPTH_W + NUM_SHIFT;
    localparam int QUO_W      = 27;
    localparam int DIV_STAGES = QUO_W;
    localparam int DREM_W     = DEN_W + 1;
    localparam int PM_W       = QUO_W + UV_W;
    localparam int CAM_FRAC   = 13;
    localparam int CAM_W      = 31;
    localparam int ZC_W       = QUO_W + 1;
    localparam int COEF_W     = 20;
    localparam int ROW_W      = 3 * COEF_W;
    localparam int OFF_W      = 32;
    localparam int PROD_W     = COEF_W + CAM_W;
    localparam int ACC_W      = 56;
    localparam int ACC_FRAC   = 20;
    localparam int RND_W      = ACC_W - ACC_FRAC;
    localparam int WORLD_W    = 32;
    localparam int CFG_IDX_W  = 3;

    // arithmetic constants
    localparam logic [SUMSQ_W-1:0] SUMSQ_ONE  = SUMSQ_W'(64'd1 << SQ_FRAC);
    localparam logic [DEN_W-1:0]   DEN_SCALE  = DEN_W'(1000);
    localparam logic [PM_W-1:0]    CAM_HALF   = PM_W'(64'd1 << (CAM_FRAC - 1));
    localparam logic [ACC_W-1:0]   ACC_HALF   = ACC_W'(64'd1 << (ACC_FRAC - 1));
    localparam logic [RND_W-1:0]   POS_LIMIT  = RND_W'(64'h7FFF_FFFF);
    localparam logic [RND_W-1:0]   NEG_LIMIT  = RND_W'(64'h8000_0000);
    localparam logic [WORLD_W-1:0] WORLD_MAX  = 32'h7FFF_FFFF;
    localparam logic [WORLD_W-1:0] WORLD_MIN  = 32'h8000_0000;

    // register reset values
    localparam logic [DEPTH_W-1:0] DEPTH_LIMIT_RESET = 16'd64000;
    localparam logic [ROW_W-1:0]   ROW_X_RESET = ROW_W'(64'd1 << 16);
    localparam logic [ROW_W-1:0]   ROW_Y_RESET = ROW_W'(64'd1 << 36);
    localparam logic [ROW_W-1:0]   ROW_Z_RESET = ROW_W'(64'd1 << 56);

    // configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_DEPTH_LIMIT = 3'd0,
        CFG_ROW_X       = 3'd1,
        CFG_ROW_Y       = 3'd2,
        CFG_ROW_Z       = 3'd3,
        CFG_OFFSET_X    = 3'd4,
        CFG_OFFSET_Y    = 3'd5,
        CFG_OFFSET_Z    = 3'd6
    } cfg_idx_t;

    // input request payload
    typedef struct packed {
        logic [DEPTH_W-1:0]      depth_mm;
        logic signed [UV_W-1:0]  unproj_u;
        logic signed [UV_W-1:0]  unproj_v;
        logic                    frame_end_in;
    } pixel_in_t;

    // output request payload
    typedef struct packed {
        logic signed [WORLD_W-1:0] world_x;
        logic signed [WORLD_W-1:0] world_y;
        logic signed [WORLD_W-1:0] world_z;
        logic                      depth_rejected;
        logic                      frame_end_out;
    } point_out_t;

    // per-pixel data that rides along the pipeline
    typedef struct packed {
        logic [DEPTH_W-1:0]      depth;
        logic signed [UV_W-1:0]  u;
        logic signed [UV_W-1:0]  v;
        logic                    rejected;
        logic                    frame_end;
    } side_t;

    // transform registers handed to the back end
    typedef struct packed {
        logic [ROW_W-1:0]        row_x;
        logic [ROW_W-1:0]        row_y;
        logic [ROW_W-1:0]        row_z;
        logic signed [OFF_W-1:0] off_x;
        logic signed [OFF_W-1:0] off_y;
        logic signed [OFF_W-1:0] off_z;
    } xform_cfg_t;

endpackage

### rtl/depth_pixel_to_world_point.sv
// top level: config registers, pipeline chain and output skid buffer
//
//   channel   signals                          direction  content
//   pixel     pix_valid / pix_ready / pix      in         depth, u, v, frame end
//   point     point_valid / point_ready / point out       world x/y/z, flags
//   config    cfg_we / cfg_index / cfg_data    in         register writes
//
// one pixel per clock while the skid register is free; from pixel accept to
// point valid a pixel passes 1 input stage, 29 square-root stages,
// 28 divide stages, 7 transform stages and 1 output register.
// reset clears all stage valids and loads the register defaults.
// the pipeline advances as one; when the output is held, one more point
// drops into the skid register before pix_ready falls.
module depth_pixel_to_world_point (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                pix_valid,
    output logic                                pix_ready,
    input  dpw_pkg::pixel_in_t                  pix,
    output logic                                point_valid,
    input  logic                                point_ready,
    output dpw_pkg::point_out_t                 point,
    input  logic                                cfg_we,
    input  logic [dpw_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [dpw_pkg::ROW_W-1:0]           cfg_data
);

    logic [dpw_pkg::DEPTH_W-1:0]       depth_limit_reg;
    dpw_pkg::xform_cfg_t               xcfg_reg;

    logic                              advance;
    logic                              f_valid;
    dpw_pkg::side_t                    f_side;
    logic [dpw_pkg::SUMSQ_W-1:0]       f_sum_sq;
    logic                              q_valid;
    dpw_pkg::side_t                    q_side;
    logic [dpw_pkg::ROOT_W-1:0]        q_root;
    logic                              d_valid;
    dpw_pkg::side_t                    d_side;
    logic [dpw_pkg::QUO_W-1:0]         d_mag;
    logic                              x_valid;
    dpw_pkg::point_out_t               x_point;

    logic                              out_valid_reg;
    dpw_pkg::point_out_t               out_reg;
    logic                              skid_valid_reg;
    dpw_pkg::point_out_t               skid_reg;
    logic                              push;
    logic                              pop;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            depth_limit_reg <= dpw_pkg::DEPTH_LIMIT_RESET;
            xcfg_reg.row_x  <= dpw_pkg::ROW_X_RESET;
            xcfg_reg.row_y  <= dpw_pkg::ROW_Y_RESET;
            xcfg_reg.row_z  <= dpw_pkg::ROW_Z_RESET;
            xcfg_reg.off_x  <= '0;
            xcfg_reg.off_y  <= '0;
            xcfg_reg.off_z  <= '0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                dpw_pkg::CFG_DEPTH_LIMIT: depth_limit_reg <= cfg_data[dpw_pkg::DEPTH_W-1:0];
                dpw_pkg::CFG_ROW_X:       xcfg_reg.row_x  <= cfg_data;
                dpw_pkg::CFG_ROW_Y:       xcfg_reg.row_y  <= cfg_data;
                dpw_pkg::CFG_ROW_Z:       xcfg_reg.row_z  <= cfg_data;
                dpw_pkg::CFG_OFFSET_X:    xcfg_reg.off_x  <= $signed(cfg_data[dpw_pkg::OFF_W-1:0]);
                dpw_pkg::CFG_OFFSET_Y:    xcfg_reg.off_y  <= $signed(cfg_data[dpw_pkg::OFF_W-1:0]);
                dpw_pkg::CFG_OFFSET_Z:    xcfg_reg.off_z  <= $signed(cfg_data[dpw_pkg::OFF_W-1:0]);
                default:                  ;
            endcase
        end
    end

    // whole pipeline moves while the skid register is free
    assign advance   = !skid_valid_reg;
    assign pix_ready = advance;

    dpw_front u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .advance     (advance),
        .in_valid    (pix_valid),
        .pix         (pix),
        .depth_limit (depth_limit_reg),
        .out_valid   (f_valid),
        .side        (f_side),
        .sum_sq      (f_sum_sq)
    );

    dpw_sqrt u_sqrt (
        .clk       (clk),
        .rst_n     (rst_n),
        .advance   (advance),
        .in_valid  (f_valid),
        .side_in   (f_side),
        .sum_sq    (f_sum_sq),
        .out_valid (q_valid),
        .side_out  (q_side),
        .root      (q_root)
    );

    dpw_div u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .advance   (advance),
        .in_valid  (q_valid),
        .side_in   (q_side),
        .root      (q_root),
        .out_valid (d_valid),
        .side_out  (d_side),
        .mag       (d_mag)
    );

    dpw_xform u_xform (
        .clk       (clk),
        .rst_n     (rst_n),
        .advance   (advance),
        .in_valid  (d_valid),
        .side_in   (d_side),
        .mag       (d_mag),
        .cfg       (xcfg_reg),
        .out_valid (x_valid),
        .point     (x_point)
    );

    // output register with one skid entry
    assign push = x_valid && advance;
    assign pop  = out_valid_reg && point_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (skid_valid_reg)
        begin
            if (pop)
            begin
                skid_valid_reg <= 1'b0;
            end
        end
        else if (push)
        begin
            if (out_valid_reg && !pop)
            begin
                skid_valid_reg <= 1'b1;
            end
            else
            begin
                out_valid_reg <= 1'b1;
            end
        end
        else if (pop)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (skid_valid_reg)
        begin
            if (pop)
            begin
                out_reg <= skid_reg;
            end
        end
        else if (push)
        begin
            if (out_valid_reg && !pop)
            begin
                skid_reg <= x_point;
            end
            else
            begin
                out_reg <= x_point;
            end
        end
    end

    assign point_valid = out_valid_reg;
    assign point       = out_reg;

`ifndef SYNTHESIS
    // skid entry only exists behind a full output register
    assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg |-> out_valid_reg)
        else $error("skid entry without output entry");

    // a held output keeps the skid entry
    assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg && !point_ready |=> skid_valid_reg)
        else $error("skid entry lost while output held");

    // skid fills only when the output was held
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(skid_valid_reg) |-> $past(point_valid && !point_ready))
        else $error("skid filled without output stall");
`endif

endmodule

### rtl/dpw_front.sv
// input stage: depth limit check and u*u + v*v + 1 in Q.26
module dpw_front (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              advance,
    input  logic                              in_valid,
    input  dpw_pkg::pixel_in_t                pix,
    input  logic [dpw_pkg::DEPTH_W-1:0]       depth_limit,
    output logic                              out_valid,
    output dpw_pkg::side_t                    side,
    output logic [dpw_pkg::SUMSQ_W-1:0]       sum_sq
);

    logic signed [dpw_pkg::SUMSQ_W-1:0] uu;
    logic signed [dpw_pkg::SUMSQ_W-1:0] vv;
    logic                               valid_reg;
    dpw_pkg::side_t                     side_reg;
    dpw_pkg::side_t                     side_next;
    logic [dpw_pkg::SUMSQ_W-1:0]        sum_sq_reg;
    logic [dpw_pkg::SUMSQ_W-1:0]        sum_sq_next;

    // squares and limit compare
    always_comb
    begin
        uu = pix.unproj_u * pix.unproj_u;
        vv = pix.unproj_v * pix.unproj_v;
        sum_sq_next = $unsigned(uu) + $unsigned(vv) + dpw_pkg::SUMSQ_ONE;
        side_next.depth     = pix.depth_mm;
        side_next.u         = pix.unproj_u;
        side_next.v         = pix.unproj_v;
        side_next.rejected  = pix.depth_mm > depth_limit;
        side_next.frame_end = pix.frame_end_in;
    end

    // stage valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            valid_reg <= in_valid;
        end
    end

    // stage payload
    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            side_reg   <= side_next;
            sum_sq_reg <= sum_sq_next;
        end
    end

    assign out_valid = valid_reg;
    assign side      = side_reg;
    assign sum_sq    = sum_sq_reg;

endmodule

### rtl/dpw_sqrt.sv
// pipelined integer square root of sum_sq * 2^26, one root bit per stage
module dpw_sqrt (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              advance,
    input  logic                              in_valid,
    input  dpw_pkg::side_t                    side_in,
    input  logic [dpw_pkg::SUMSQ_W-1:0]       sum_sq,
    output logic                              out_valid,
    output dpw_pkg::side_t                    side_out,
    output logic [dpw_pkg::ROOT_W-1:0]        root
);

    localparam int N = dpw_pkg::SQ_STAGES;

    logic                            valid_reg [N];
    dpw_pkg::side_t                  side_reg  [N];
    logic [dpw_pkg::REM_W-1:0]       rem_reg   [N];
    logic [dpw_pkg::ROOT_W-1:0]      root_reg  [N];
    logic [dpw_pkg::RAD_W-1:0]       rad_reg   [N];

    logic                            src_valid [N];
    dpw_pkg::side_t                  src_side  [N];
    logic [dpw_pkg::REM_W-1:0]       src_rem   [N];
    logic [dpw_pkg::ROOT_W-1:0]      src_root  [N];
    logic [dpw_pkg::RAD_W-1:0]       src_rad   [N];

    logic [dpw_pkg::REM_W-1:0]       cur       [N];
    logic [dpw_pkg::REM_W-1:0]       trial     [N];
    logic                            take      [N];
    logic [dpw_pkg::REM_W-1:0]       rem_next  [N];
    logic [dpw_pkg::ROOT_W-1:0]      root_next [N];
    logic [dpw_pkg::RAD_W-1:0]       rad_next  [N];

    // each stage brings down two radicand bits and tries 4*root+1
    always_comb
    begin
        src_valid[0] = in_valid;
        src_side[0]  = side_in;
        src_rem[0]   = '0;
        src_root[0]  = '0;
        src_rad[0]   = {sum_sq, {dpw_pkg::SQ_FRAC{1'b0}}};
        for (int k = 1; k < N; k++)
        begin
            src_valid[k] = valid_reg[k-1];
            src_side[k]  = side_reg[k-1];
            src_rem[k]   = rem_reg[k-1];
            src_root[k]  = root_reg[k-1];
            src_rad[k]   = rad_reg[k-1];
        end
        for (int k = 0; k < N; k++)
        begin
            cur[k]   = {src_rem[k][dpw_pkg::REM_W-3:0],
                        src_rad[k][dpw_pkg::RAD_W-1 -: 2]};
            trial[k] = {{(dpw_pkg::REM_W - dpw_pkg::ROOT_W - 2){1'b0}},
                        src_root[k], 2'b01};
            take[k]  = cur[k] >= trial[k];
            rem_next[k]  = take[k] ? (cur[k] - trial[k]) : cur[k];
            root_next[k] = {src_root[k][dpw_pkg::ROOT_W-2:0], take[k]};
            rad_next[k]  = {src_rad[k][dpw_pkg::RAD_W-3:0], 2'b00};
        end
    end

    // stage valids
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < N; k++)
            begin
                valid_reg[k] <= 1'b0;
            end
        end
        else if (advance)
        begin
            for (int k = 0; k < N; k++)
            begin
                valid_reg[k] <= src_valid[k];
            end
        end
    end

    // stage payload
    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            for (int k = 0; k < N; k++)
            begin
                side_reg[k] <= src_side[k];
                rem_reg[k]  <= rem_next[k];
                root_reg[k] <= root_next[k];
                rad_reg[k]  <= rad_next[k];
            end
        end
    end

    assign out_valid = valid_reg[N-1];
    assign side_out  = side_reg[N-1];
    assign root      = root_reg[N-1];

endmodule

### rtl/dpw_div.sv
// pipelined rounded divide depth * 2^46 / (1000 * root), one quotient bit per stage
module dpw_div (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              advance,
    input  logic                              in_valid,
    input  dpw_pkg::side_t                    side_in,
    input  logic [dpw_pkg::ROOT_W-1:0]        root,
    output logic                              out_valid,
    output dpw_pkg::side_t                    side_out,
    output logic [dpw_pkg::QUO_W-1:0]         mag
);

    localparam int N = dpw_pkg::DIV_STAGES;

    // denominator stage
    logic                            den_valid_reg;
    dpw_pkg::side_t                  den_side_reg;
    logic [dpw_pkg::DEN_W-1:0]       den_reg;
    logic [dpw_pkg::NUM_W-1:0]       num;

    logic                            valid_reg [N];
    dpw_pkg::side_t                  side_reg  [N];
    logic [dpw_pkg::DEN_W-1:0]       dv_reg    [N];
    logic [dpw_pkg::DREM_W-1:0]      rem_reg   [N];
    logic [dpw_pkg::QUO_W-1:0]       quo_reg   [N];
    logic [dpw_pkg::QUO_W-1:0]       low_reg   [N];

    logic                            src_valid [N];
    dpw_pkg::side_t                  src_side  [N];
    logic [dpw_pkg::DEN_W-1:0]       src_dv    [N];
    logic [dpw_pkg::DREM_W-1:0]      src_rem   [N];
    logic [dpw_pkg::QUO_W-1:0]       src_quo   [N];
    logic [dpw_pkg::QUO_W-1:0]       src_low   [N];

    logic [dpw_pkg::DREM_W-1:0]      cur       [N];
    logic                            take      [N];
    logic [dpw_pkg::DREM_W-1:0]      rem_next  [N];
    logic [dpw_pkg::QUO_W-1:0]       quo_next  [N];
    logic [dpw_pkg::QUO_W-1:0]       low_next  [N];

    // numerator with half the denominator added for round to nearest
    assign num = {den_side_reg.depth, {dpw_pkg::NUM_SHIFT{1'b0}}}
               | {{(dpw_pkg::NUM_W - dpw_pkg::DEN_W + 1){1'b0}},
                  den_reg[dpw_pkg::DEN_W-1:1]};

    // restoring divide, the remainder always stays below the denominator
    always_comb
    begin
        src_valid[0] = den_valid_reg;
        src_side[0]  = den_side_reg;
        src_dv[0]    = den_reg;
        src_rem[0]   = dpw_pkg::DREM_W'(num[dpw_pkg::NUM_W-1:dpw_pkg::QUO_W]);
        src_quo[0]   = '0;
        src_low[0]   = num[dpw_pkg::QUO_W-1:0];
        for (int k = 1; k < N; k++)
        begin
            src_valid[k] = valid_reg[k-1];
            src_side[k]  = side_reg[k-1];
            src_dv[k]    = dv_reg[k-1];
            src_rem[k]   = rem_reg[k-1];
            src_quo[k]   = quo_reg[k-1];
            src_low[k]   = low_reg[k-1];
        end
        for (int k = 0; k < N; k++)
        begin
            cur[k]  = {src_rem[k][dpw_pkg::DREM_W-2:0], src_low[k][dpw_pkg::QUO_W-1]};
            take[k] = cur[k] >= {1'b0, src_dv[k]};
            rem_next[k] = take[k] ? (cur[k] - {1'b0, src_dv[k]}) : cur[k];
            quo_next[k] = {src_quo[k][dpw_pkg::QUO_W-2:0], take[k]};
            low_next[k] = {src_low[k][dpw_pkg::QUO_W-2:0], 1'b0};
        end
    end

    // stage valids
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            den_valid_reg <= 1'b0;
            for (int k = 0; k < N; k++)
            begin
                valid_reg[k] <= 1'b0;
            end
        end
        else if (advance)
        begin
            den_valid_reg <= in_valid;
            for (int k = 0; k < N; k++)
            begin
                valid_reg[k] <= src_valid[k];
            end
        end
    end

    // stage payload
    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            den_side_reg <= side_in;
            den_reg      <= dpw_pkg::DEN_W'(root) * dpw_pkg::DEN_SCALE;
            for (int k = 0; k < N; k++)
            begin
                side_reg[k] <= src_side[k];
                dv_reg[k]   <= src_dv[k];
                rem_reg[k]  <= rem_next[k];
                quo_reg[k]  <= quo_next[k];
                low_reg[k]  <= low_next[k];
            end
        end
    end

    assign out_valid = valid_reg[N-1];
    assign side_out  = side_reg[N-1];
    assign mag       = quo_reg[N-1];

endmodule

### rtl/dpw_xform.sv
// camera point from |Z|, then the rigid transform, rounding and saturation
module dpw_xform (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              advance,
    input  logic                              in_valid,
    input  dpw_pkg::side_t                    side_in,
    input  logic [dpw_pkg::QUO_W-1:0]         mag,
    input  dpw_pkg::xform_cfg_t               cfg,
    output logic                              out_valid,
    output dpw_pkg::point_out_t               point
);

    localparam int NS = 7;

    logic                                  valid_reg [NS];

    // coefficient and offset views of the configuration
    logic [dpw_pkg::ROW_W-1:0]             rows      [3];
    logic signed [dpw_pkg::OFF_W-1:0]      offs      [3];

    // stage 1: magnitude products
    logic [dpw_pkg::QUO_W-1:0]             mag_eff;
    logic [dpw_pkg::UV_W-1:0]              abs_u;
    logic [dpw_pkg::UV_W-1:0]              abs_v;
    dpw_pkg::side_t                        s1_side_reg;
    logic [dpw_pkg::PM_W-1:0]              s1_pm_u_reg;
    logic [dpw_pkg::PM_W-1:0]              s1_pm_v_reg;
    logic signed [dpw_pkg::ZC_W-1:0]       s1_zc_reg;

    // stage 2: camera point
    logic [dpw_pkg::PM_W-1:0]              rnd_u;
    logic [dpw_pkg::PM_W-1:0]              rnd_v;
    logic signed [dpw_pkg::CAM_W-1:0]      mu;
    logic signed [dpw_pkg::CAM_W-1:0]      mv;
    dpw_pkg::side_t                        s2_side_reg;
    logic signed [dpw_pkg::CAM_W-1:0]      s2_cam_reg [3];

    // stage 3 to 7: per axis
    dpw_pkg::side_t                        s3_side_reg;
    logic signed [dpw_pkg::PROD_W-1:0]     s3_prod_reg [3][3];
    logic signed [dpw_pkg::ACC_W-1:0]      s3_off_reg  [3];
    dpw_pkg::side_t                        s4_side_reg;
    logic signed [dpw_pkg::ACC_W-1:0]      s4_sa_reg   [3];
    logic signed [dpw_pkg::ACC_W-1:0]      s4_sb_reg   [3];
    dpw_pkg::side_t                        s5_side_reg;
    logic signed [dpw_pkg::ACC_W-1:0]      s5_acc_reg  [3];
    dpw_pkg::side_t                        s6_side_reg;
    logic                                  s6_neg_reg  [3];
    logic [dpw_pkg::ACC_W-1:0]             s6_abs_reg  [3];
    dpw_pkg::side_t                        s7_side_reg;
    logic [dpw_pkg::WORLD_W-1:0]           s7_world_reg [3];

    logic signed [dpw_pkg::COEF_W-1:0]     coef [3][3];
    logic [dpw_pkg::RND_W-1:0]             rnd  [3];
    logic [dpw_pkg::WORLD_W-1:0]           world_next [3];

    assign rows[0] = cfg.row_x;
    assign rows[1] = cfg.row_y;
    assign rows[2] = cfg.row_z;
    assign offs[0] = cfg.off_x;
    assign offs[1] = cfg.off_y;
    assign offs[2] = cfg.off_z;

    // rejected pixels contribute a zero camera point
    always_comb
    begin
        mag_eff = side_in.rejected ? '0 : mag;
        abs_u   = side_in.u[dpw_pkg::UV_W-1] ? dpw_pkg::UV_W'(-side_in.u)
                                              : dpw_pkg::UV_W'(side_in.u);
        abs_v   = side_in.v[dpw_pkg::UV_W-1] ? dpw_pkg::UV_W'(-side_in.v)
                                              : dpw_pkg::UV_W'(side_in.v);
    end

    // Z*u and Z*v rounded half away from zero; Z is never positive
    always_comb
    begin
        rnd_u = (s1_pm_u_reg + dpw_pkg::CAM_HALF) >> dpw_pkg::CAM_FRAC;
        rnd_v = (s1_pm_v_reg + dpw_pkg::CAM_HALF) >> dpw_pkg::CAM_FRAC;
        mu = $signed(rnd_u[dpw_pkg::CAM_W-1:0]);
        mv = $signed(rnd_v[dpw_pkg::CAM_W-1:0]);
    end

    // coefficient unpack, final rounding and clamp
    always_comb
    begin
        for (int a = 0; a < 3; a++)
        begin
            for (int j = 0; j < 3; j++)
            begin
                coef[a][j] = $signed(rows[a][j*dpw_pkg::COEF_W +: dpw_pkg::COEF_W]);
            end
            rnd[a] = dpw_pkg::RND_W'((s6_abs_reg[a] + dpw_pkg::ACC_HALF)
                                     >> dpw_pkg::ACC_FRAC);
            if (s6_neg_reg[a])
            begin
                world_next[a] = (rnd[a] > dpw_pkg::NEG_LIMIT) ? dpw_pkg::WORLD_MIN
                              : dpw_pkg::WORLD_W'(0) - rnd[a][dpw_pkg::WORLD_W-1:0];
            end
            else
            begin
                world_next[a] = (rnd[a] > dpw_pkg::POS_LIMIT) ? dpw_pkg::WORLD_MAX
                              : rnd[a][dpw_pkg::WORLD_W-1:0];
            end
        end
    end

    // stage valids
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < NS; k++)
            begin
                valid_reg[k] <= 1'b0;
            end
        end
        else if (advance)
        begin
            valid_reg[0] <= in_valid;
            for (int k = 1; k < NS; k++)
            begin
                valid_reg[k] <= valid_reg[k-1];
            end
        end
    end

    // stage payload
    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            s1_side_reg <= side_in;
            s1_pm_u_reg <= dpw_pkg::PM_W'(mag_eff) * dpw_pkg::PM_W'(abs_u);
            s1_pm_v_reg <= dpw_pkg::PM_W'(mag_eff) * dpw_pkg::PM_W'(abs_v);
            s1_zc_reg   <= dpw_pkg::ZC_W'(0) - dpw_pkg::ZC_W'(mag_eff);

            s2_side_reg   <= s1_side_reg;
            s2_cam_reg[0] <= s1_side_reg.u[dpw_pkg::UV_W-1] ? mu : -mu;
            s2_cam_reg[1] <= s1_side_reg.v[dpw_pkg::UV_W-1] ? mv : -mv;
            s2_cam_reg[2] <= dpw_pkg::CAM_W'(s1_zc_reg);

            s3_side_reg <= s2_side_reg;
            s4_side_reg <= s3_side_reg;
            s5_side_reg <= s4_side_reg;
            s6_side_reg <= s5_side_reg;
            s7_side_reg <= s6_side_reg;
            for (int a = 0; a < 3; a++)
            begin
                for (int j = 0; j < 3; j++)
                begin
                    s3_prod_reg[a][j] <= dpw_pkg::PROD_W'(coef[a][j])
                                       * dpw_pkg::PROD_W'(s2_cam_reg[j]);
                end
                s3_off_reg[a] <= dpw_pkg::ACC_W'(offs[a]) <<< dpw_pkg::ACC_FRAC;
                s4_sa_reg[a]  <= dpw_pkg::ACC_W'(s3_prod_reg[a][0])
                               + dpw_pkg::ACC_W'(s3_prod_reg[a][1]);
                s4_sb_reg[a]  <= dpw_pkg::ACC_W'(s3_prod_reg[a][2]) + s3_off_reg[a];
                s5_acc_reg[a] <= s4_sa_reg[a] + s4_sb_reg[a];
                s6_neg_reg[a] <= s5_acc_reg[a][dpw_pkg::ACC_W-1];
                s6_abs_reg[a] <= s5_acc_reg[a][dpw_pkg::ACC_W-1]
                               ? $unsigned(-s5_acc_reg[a]) : $unsigned(s5_acc_reg[a]);
                s7_world_reg[a] <= world_next[a];
            end
        end
    end

    assign out_valid            = valid_reg[NS-1];
    assign point.world_x        = $signed(s7_world_reg[0]);
    assign point.world_y        = $signed(s7_world_reg[1]);
    assign point.world_z        = $signed(s7_world_reg[2]);
    assign point.depth_rejected = s7_side_reg.rejected;
    assign point.frame_end_out  = s7_side_reg.frame_end;

endmodule
